FILE: sv/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg
// Shared types, constants and elaboration-time helpers for the compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package adrc_pkg;

    // default geometry
    localparam int SAMPLE_BITS     = 16;
    localparam int GAIN_TABLE_BITS = 10;
    localparam int STEP_BITS       = 4;
    localparam int CFG_ADDR_BITS   = 4;

    // register reset values
    localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
    localparam logic [16:0]        INV_RATIO_RESET = 17'd16384;
    localparam logic [23:0]        ATTACK_RESET    = 24'd16431309;
    localparam logic [23:0]        RELEASE_RESET   = 24'd16773721;

    // arithmetic constants
    localparam logic [16:0]        RATIO_ONE    = 17'd65536;
    localparam logic [24:0]        COEF_ONE     = 25'd16777216;
    localparam logic [14:0]        DB_FLOOR_MAG = 15'd20480;
    localparam logic signed [15:0] DB_FLOOR     = -16'sd20480;
    localparam logic [17:0]        DB_PER_OCT   = 18'd197283;
    localparam logic [21:0]        OCT_PER_DB   = 22'd2786635;

    // register map
    typedef enum logic [1:0] {
        REG_THRESHOLD,
        REG_INV_RATIO,
        REG_ATTACK,
        REG_RELEASE
    } adrc_reg_t;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [16:0]        inverse_ratio;
        logic [23:0]        attack_coef;
        logic [23:0]        release_coef;
    } adrc_cfg_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_ENV_A,
        OP_ENV_B,
        OP_NORM,
        OP_LOG,
        OP_LEVEL,
        OP_GAIN,
        OP_OCT,
        OP_EXP,
        OP_SHIFT,
        OP_EMIT
    } adrc_op_t;

    typedef struct packed {
        adrc_op_t               op;
        logic [STEP_BITS-1:0]   step;
    } adrc_cmd_t;

    // truncating integer square root, used only on constants
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-idx) in Q1.30, built by the truncating root chain
    function automatic logic [31:0] exp_coef(input int idx);
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int j = 2; j <= idx; j++)
        begin
            c = isqrt64(c << 30);
        end
        return c[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/adrc_sample_if.sv
// ----------------------------------------------------------------------------
// adrc_sample_if
// Valid/ready channel carrying one input audio sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface adrc_sample_if #(
    parameter int SampleBits = adrc_pkg::SAMPLE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [SampleBits-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: sv/adrc_result_if.sv
// ----------------------------------------------------------------------------
// adrc_result_if
// Valid/ready channel carrying one compressed sample and its gain.
// ----------------------------------------------------------------------------
`default_nettype none

interface adrc_result_if #(
    parameter int SampleBits = adrc_pkg::SAMPLE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [SampleBits-1:0] sample_out;
    logic signed [15:0]           gain_change_db;

    modport source (output valid, output sample_out, output gain_change_db, input ready);
    modport sink (input valid, input sample_out, input gain_change_db, output ready);
endinterface

`default_nettype wire

FILE: sv/adrc_regs.sv
// ----------------------------------------------------------------------------
// adrc_regs
// APB register file holding threshold, ratio and smoothing coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module adrc_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adrc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output adrc_pkg::adrc_cfg_t               cfg
);
    import adrc_pkg::*;

    adrc_cfg_t cfg_reg;
    adrc_reg_t sel;
    logic      wr_en;

    assign sel   = adrc_reg_t'(paddr[3:2]);
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db  <= THRESHOLD_RESET;
            cfg_reg.inverse_ratio <= INV_RATIO_RESET;
            cfg_reg.attack_coef   <= ATTACK_RESET;
            cfg_reg.release_coef  <= RELEASE_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_THRESHOLD: cfg_reg.threshold_db  <= pwdata[15:0];
                REG_INV_RATIO: cfg_reg.inverse_ratio <= pwdata[16:0];
                REG_ATTACK:    cfg_reg.attack_coef   <= pwdata[23:0];
                REG_RELEASE:   cfg_reg.release_coef  <= pwdata[23:0];
                default:       cfg_reg.release_coef  <= cfg_reg.release_coef;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (sel)
            REG_THRESHOLD: prdata = {16'd0, cfg_reg.threshold_db};
            REG_INV_RATIO: prdata = {15'd0, cfg_reg.inverse_ratio};
            REG_ATTACK:    prdata = {8'd0, cfg_reg.attack_coef};
            REG_RELEASE:   prdata = {8'd0, cfg_reg.release_coef};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/adrc_ctrl.sv
// ----------------------------------------------------------------------------
// adrc_ctrl
// Sequencer stepping the datapath through one sample and owning handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module adrc_ctrl #(
    parameter int GainTableBits = adrc_pkg::GAIN_TABLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output adrc_pkg::adrc_cmd_t cmd
);
    import adrc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ENV_A,
        S_ENV_B,
        S_NORM,
        S_LOG,
        S_LEVEL,
        S_GAIN,
        S_OCT,
        S_EXP,
        S_SHIFT,
        S_EMIT
    } state_t;

    localparam logic [STEP_BITS-1:0] NormLast = STEP_BITS'(4);
    localparam logic [STEP_BITS-1:0] LogLast  = STEP_BITS'(15);
    localparam logic [STEP_BITS-1:0] ExpLast  = STEP_BITS'(GainTableBits - 1);

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 emit_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign emit_ok   = !out_valid_reg || out_ready;

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.step       = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = S_ENV_A;
            end
            S_ENV_A:
            begin
                cmd.op     = OP_ENV_A;
                state_next = S_ENV_B;
            end
            S_ENV_B:
            begin
                cmd.op     = OP_ENV_B;
                step_next  = '0;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                cmd.op = OP_NORM;
                if (step_reg == NormLast)
                begin
                    step_next  = '0;
                    state_next = S_LOG;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_LOG:
            begin
                cmd.op = OP_LOG;
                if (step_reg == LogLast)
                begin
                    step_next  = '0;
                    state_next = S_LEVEL;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_LEVEL:
            begin
                cmd.op     = OP_LEVEL;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = S_OCT;
            end
            S_OCT:
            begin
                cmd.op     = OP_OCT;
                step_next  = '0;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.op = OP_EXP;
                if (step_reg == ExpLast)
                begin
                    step_next  = '0;
                    state_next = S_SHIFT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.op     = OP_SHIFT;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait until the output register is free
                if (emit_ok)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/adrc_dp.sv
// ----------------------------------------------------------------------------
// adrc_dp
// Datapath: envelope, log level, gain curve and linear gain on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module adrc_dp #(
    parameter int SampleBits    = adrc_pkg::SAMPLE_BITS,
    parameter int GainTableBits = adrc_pkg::GAIN_TABLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  adrc_pkg::adrc_cmd_t   cmd,
    input  adrc_pkg::adrc_cfg_t   cfg,
    input  logic [SampleBits-1:0] sample_in,
    output logic [SampleBits-1:0] sample_out,
    output logic [15:0]           gain_change_db
);
    import adrc_pkg::*;

    localparam int PowFrac     = 2 * (SampleBits - 1);
    localparam int PowDn       = (PowFrac >= 30) ? PowFrac - 30 : 0;
    localparam int PowUp       = (PowFrac < 30) ? 30 - PowFrac : 0;
    localparam int CoefIdxBits = $clog2(GainTableBits);
    localparam logic [63:0] OctRound = 64'd1 << (31 - GainTableBits);
    localparam logic [30:0] GainUnit = 31'd1 << 30;

    logic                     sign_reg;
    logic [SampleBits-1:0]    ax_reg;
    logic [30:0]              pow_reg;
    logic [31:0]              env_reg;
    logic [23:0]              coef_reg;
    logic [55:0]              acc_reg;
    logic [31:0]              mant_reg;
    logic [4:0]               cnt_reg;
    logic [15:0]              frac_reg;
    logic signed [15:0]       lvl_reg;
    logic [14:0]              gmag_reg;
    logic                     nbig_reg;
    logic [4:0]               nsh_reg;
    logic [GainTableBits-1:0] fbits_reg;
    logic [30:0]              gain_reg;
    logic [SampleBits-1:0]    sout_reg;
    logic [15:0]              gout_reg;

    logic [31:0]              coef_tab [GainTableBits];
    logic [31:0]              mul_a, mul_b;
    logic [63:0]              prod;
    logic [23:0]              coef_sel;
    logic [63:0]              pow_full;
    logic [56:0]              env_sum;
    logic [20:0]              oct_dist;
    logic [63:0]              lvl_sum;
    logic [15:0]              lvl_mag;
    logic signed [16:0]       diff;
    logic                     above;
    logic [16:0]              r_eff;
    logic [16:0]              one_minus;
    logic [63:0]              gain_sum;
    logic [17:0]              gain_t;
    logic [63:0]              oct_sum;
    logic [63:0]              rnd_sum;
    logic [SampleBits-1:0]    out_q;

    // fractional-octave coefficients 2^(-2^-(i+1))
    for (genvar gi = 0; gi < GainTableBits; gi++)
    begin : g_coef
        assign coef_tab[gi] = exp_coef(gi + 1);
    end

    // shared multiplier operand select
    assign coef_sel = ({1'b0, pow_reg} > env_reg) ? cfg.attack_coef : cfg.release_coef;
    assign oct_dist = (cnt_reg == 5'd0) ? 21'd0 : ({cnt_reg, 16'd0} - {5'd0, frac_reg});
    assign diff     = {lvl_reg[15], lvl_reg} - {cfg.threshold_db[15], cfg.threshold_db};
    assign above    = (diff > 17'sd0);
    assign r_eff    = (cfg.inverse_ratio > RATIO_ONE) ? RATIO_ONE : cfg.inverse_ratio;
    assign one_minus = RATIO_ONE - r_eff;

    always_comb
    begin
        case (cmd.op)
            OP_SQUARE:
            begin
                mul_a = 32'(ax_reg);
                mul_b = 32'(ax_reg);
            end
            OP_ENV_A:
            begin
                mul_a = 32'(coef_sel);
                mul_b = env_reg;
            end
            OP_ENV_B:
            begin
                mul_a = 32'(COEF_ONE - {1'b0, coef_reg});
                mul_b = 32'(pow_reg);
            end
            OP_LOG:
            begin
                mul_a = mant_reg;
                mul_b = mant_reg;
            end
            OP_LEVEL:
            begin
                mul_a = 32'(oct_dist);
                mul_b = 32'(DB_PER_OCT);
            end
            OP_GAIN:
            begin
                mul_a = 32'(one_minus);
                mul_b = 32'(diff[16:0]);
            end
            OP_OCT:
            begin
                mul_a = 32'(gmag_reg);
                mul_b = 32'(OCT_PER_DB);
            end
            OP_EXP:
            begin
                mul_a = 32'(gain_reg);
                mul_b = coef_tab[cmd.step[CoefIdxBits-1:0]];
            end
            OP_EMIT:
            begin
                mul_a = 32'(ax_reg);
                mul_b = 32'(gain_reg);
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // post-multiply rounding and alignment
    assign pow_full = (prod >> PowDn) << PowUp;
    assign env_sum  = {1'b0, acc_reg} + 57'(prod) + (57'd1 << 23);
    assign lvl_sum  = prod + (64'd1 << 23);
    assign lvl_mag  = lvl_sum[39:24];
    assign gain_sum = prod + 64'd32768;
    assign gain_t   = gain_sum[33:16];
    assign oct_sum  = prod + OctRound;
    assign rnd_sum  = prod + (64'd1 << 29);
    assign out_q    = rnd_sum[SampleBits+29:30];

    // envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg <= 32'd0;
        end
        else if (cmd.op == OP_ENV_B)
        begin
            env_reg <= env_sum[55:24];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                sign_reg <= sample_in[SampleBits-1];
                ax_reg   <= sample_in[SampleBits-1] ? (SampleBits'(0) - sample_in) : sample_in;
            end
            OP_SQUARE:
            begin
                pow_reg <= pow_full[30:0];
            end
            OP_ENV_A:
            begin
                coef_reg <= coef_sel;
                acc_reg  <= prod[55:0];
            end
            OP_ENV_B:
            begin
                mant_reg <= env_sum[55:24];
                cnt_reg  <= 5'd0;
            end
            OP_NORM:
            begin
                // binary search for the leading one, target bit 30
                case (cmd.step)
                    4'd0:
                    begin
                        if (mant_reg[30:15] == 16'd0)
                        begin
                            mant_reg <= mant_reg << 16;
                            cnt_reg  <= cnt_reg + 5'd16;
                        end
                    end
                    4'd1:
                    begin
                        if (mant_reg[30:23] == 8'd0)
                        begin
                            mant_reg <= mant_reg << 8;
                            cnt_reg  <= cnt_reg + 5'd8;
                        end
                    end
                    4'd2:
                    begin
                        if (mant_reg[30:27] == 4'd0)
                        begin
                            mant_reg <= mant_reg << 4;
                            cnt_reg  <= cnt_reg + 5'd4;
                        end
                    end
                    4'd3:
                    begin
                        if (mant_reg[30:29] == 2'd0)
                        begin
                            mant_reg <= mant_reg << 2;
                            cnt_reg  <= cnt_reg + 5'd2;
                        end
                    end
                    4'd4:
                    begin
                        if (!mant_reg[30])
                        begin
                            mant_reg <= mant_reg << 1;
                            cnt_reg  <= cnt_reg + 5'd1;
                        end
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end
            OP_LOG:
            begin
                // one log2 fraction bit per squaring
                if (prod[61])
                begin
                    mant_reg <= {1'b0, prod[61:31]};
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    mant_reg <= prod[61:30];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            OP_LEVEL:
            begin
                if (env_reg == 32'd0)
                begin
                    lvl_reg <= DB_FLOOR;
                end
                else if (env_reg[31])
                begin
                    lvl_reg <= 16'sd0;
                end
                else if (lvl_mag > 16'(DB_FLOOR_MAG))
                begin
                    lvl_reg <= DB_FLOOR;
                end
                else
                begin
                    lvl_reg <= 16'd0 - lvl_mag;
                end
            end
            OP_GAIN:
            begin
                if (!above)
                begin
                    gmag_reg <= 15'd0;
                end
                else if (gain_t > 18'(DB_FLOOR_MAG))
                begin
                    gmag_reg <= DB_FLOOR_MAG;
                end
                else
                begin
                    gmag_reg <= gain_t[14:0];
                end
            end
            OP_OCT:
            begin
                nbig_reg  <= |oct_sum[63:37];
                nsh_reg   <= oct_sum[36:32];
                fbits_reg <= oct_sum[31:32-GainTableBits];
                gain_reg  <= GainUnit;
            end
            OP_EXP:
            begin
                if (fbits_reg[GainTableBits-1])
                begin
                    gain_reg <= rnd_sum[60:30];
                end
                fbits_reg <= fbits_reg << 1;
            end
            OP_SHIFT:
            begin
                gain_reg <= nbig_reg ? 31'd0 : (gain_reg >> nsh_reg);
            end
            OP_EMIT:
            begin
                sout_reg <= sign_reg ? (SampleBits'(0) - out_q) : out_q;
                gout_reg <= 16'd0 - 16'(gmag_reg);
            end
            default:
            begin
                sign_reg <= sign_reg;
            end
        endcase
    end

    assign sample_out     = sout_reg;
    assign gain_change_db = gout_reg;

endmodule

`default_nettype wire

FILE: sv/audio_dynamic_range_compressor_unit.sv
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor_unit
// Feedforward hard-knee compressor: envelope, dB level, gain curve, scaling.
// ----------------------------------------------------------------------------
//   channel       dir   handshake          payload
//   sample_chan   in    valid / ready      sample_in
//   result_chan   out   valid / ready      sample_out, gain_change_db
//   apb           in    psel/penable/...   threshold, ratio, attack, release
//
// Each sample is sequenced around the single shared 32x32 multiplier: 16 log2
// squarings, GAIN_TABLE_BITS gain products, five normalize steps and the
// envelope and output products.
// rst_n clears the envelope to zero and loads register defaults.
// A finished result waits in the output register; the next sample is taken
// meanwhile and stalls only at its own emit step until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dynamic_range_compressor_unit #(
    parameter int SampleBits    = adrc_pkg::SAMPLE_BITS,
    parameter int GainTableBits = adrc_pkg::GAIN_TABLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    adrc_sample_if.sink                        sample_chan,
    adrc_result_if.source                      result_chan,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adrc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import adrc_pkg::*;

    adrc_cfg_t             cfg;
    adrc_cmd_t             cmd;
    logic [SampleBits-1:0] sample_out;
    logic [15:0]           gain_db;

    assign pready = 1'b1;

    // configuration registers
    adrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer
    adrc_ctrl #(
        .GainTableBits (GainTableBits)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_chan.valid),
        .in_ready  (sample_chan.ready),
        .out_valid (result_chan.valid),
        .out_ready (result_chan.ready),
        .cmd       (cmd)
    );

    // arithmetic
    adrc_dp #(
        .SampleBits    (SampleBits),
        .GainTableBits (GainTableBits)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .sample_in      (sample_chan.sample_in),
        .sample_out     (sample_out),
        .gain_change_db (gain_db)
    );

    assign result_chan.sample_out     = sample_out;
    assign result_chan.gain_change_db = gain_db;

endmodule

`default_nettype wire
